@@ design/bfdl_pkg.sv @@
// Package for the bidirectional fixed delay line.
// Holds the sequencer state type, register map, field codes and default sizes.
// No dependencies.
`default_nettype none

package bfdl_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_TAG_WIDTH   = 32;

    // Fixed widths of the item fields
    localparam int TAG_PORT_W  = 32;
    localparam int STAMP_W     = 32;
    localparam int DELAY_W     = 16;

    // At most this many results leave on one tick
    localparam int RESULT_CAP  = 32;
    localparam int RES_CNT_W   = $clog2(RESULT_CAP + 1);

    // Configuration port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam logic REG_DELAY_TICKS = 1'b0;

    // Field codes
    localparam logic MODE_ARRIVAL = 1'b0;
    localparam logic MODE_TICK    = 1'b1;
    localparam logic DIR_LR       = 1'b0;
    localparam logic DIR_RL       = 1'b1;

    // Tick sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

@@ design/bidirectional_fixed_delay_line_top.sv @@
// Top level of the bidirectional fixed delay line: two timestamped FIFOs,
// the tick sequencer with its shared age compare, and the APB register.
// Depends on bfdl_pkg.
//
// Usage:
//   Items enter on start/i_mode/i_direction/i_packet_tag and are taken at an
//   edge where start is high and busy is low. Results leave on o_valid with
//   o_out_tag, o_out_direction, o_dropped and o_last, one cycle each; the
//   receiver must take them as they come.
//   An arrival is stamped and queued, or, with a zero delay or a full queue,
//   its single result shows on the next cycle. busy stays low, so arrivals
//   may follow each other every cycle.
//   A tick advances the time counter and then walks the heads of both
//   queues, left to right first, through one shared age subtract/compare.
//   Each head look is a head memory read, then a compare; busy stays high
//   until each queue stops on an entry that is not yet due, runs empty or
//   meets the result cap, and the held result has been flushed. Each
//   result leaves one look behind the entry it carries so that o_last
//   can be set.
//   The user writes delay_ticks through the APB port only while busy is low;
//   the block does not enforce it. Reset empties both queues, clears the time
//   counter and the delay; the queue memories are not cleared.
`default_nettype none

module bidirectional_fixed_delay_line_top
    import bfdl_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = DEF_TAG_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item input
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic                  i_mode,
    input  wire logic                  i_direction,
    input  wire logic [TAG_PORT_W-1:0] i_packet_tag,
    // result output
    output logic                       o_valid,
    output logic [TAG_PORT_W-1:0]      o_out_tag,
    output logic                       o_out_direction,
    output logic                       o_dropped,
    output logic                       o_last,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = (TAG_WIDTH < TAG_PORT_W) ? TAG_WIDTH : TAG_PORT_W;
    localparam logic [CW-1:0] DEPTH_C  = CW'(QUEUE_DEPTH);
    localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [RES_CNT_W-1:0] CAP_C = RES_CNT_W'(RESULT_CAP);

    // Queue memories
    logic [TW-1:0]      lr_tag_mem   [QUEUE_DEPTH];
    logic [STAMP_W-1:0] lr_stamp_mem [QUEUE_DEPTH];
    logic [TW-1:0]      rl_tag_mem   [QUEUE_DEPTH];
    logic [STAMP_W-1:0] rl_stamp_mem [QUEUE_DEPTH];

    // Control state
    t_state               r_state, n_state;
    logic [DELAY_W-1:0]   r_delay;
    logic [STAMP_W-1:0]   r_time, n_time;
    logic [IW-1:0]        r_lr_head, n_lr_head, r_rl_head, n_rl_head;
    logic [CW-1:0]        r_lr_count, n_lr_count, r_rl_count, n_rl_count;
    logic                 r_sel, n_sel;
    logic [RES_CNT_W-1:0] r_k, n_k;
    logic                 r_pend_valid, n_pend_valid;
    logic                 r_valid, n_valid;

    // Payload registers
    logic [TW-1:0]        r_pend_tag, n_pend_tag;
    logic                 r_pend_dir, n_pend_dir;
    logic [TW-1:0]        r_out_tag, n_out_tag;
    logic                 r_out_dir, n_out_dir;
    logic                 r_dropped, n_dropped;
    logic                 r_last, n_last;
    logic [TW-1:0]        r_lr_rd_tag, r_rl_rd_tag;
    logic [STAMP_W-1:0]   r_lr_rd_stamp, r_rl_rd_stamp;

    // Combinational helpers
    logic                 accept;
    logic                 cfg_wr;
    logic [TW-1:0]        in_tag;
    logic [IW-1:0]        arr_head;
    logic [CW-1:0]        arr_count;
    logic [IW:0]          tail_sum;
    logic [IW-1:0]        tail_idx;
    logic                 wr_lr, wr_rl;
    logic [CW-1:0]        sel_count;
    logic [TW-1:0]        cand_tag;
    logic [STAMP_W-1:0]   cand_stamp;
    logic [STAMP_W-1:0]   age;
    logic                 q_skip;
    logic                 q_due;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);
    assign in_tag = i_packet_tag[TW-1:0];

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DELAY_TICKS);
    assign prdata = (paddr[2] == REG_DELAY_TICKS) ?
                    {{(APB_DATA_W - DELAY_W){1'b0}}, r_delay} : '0;

    // Tail position of the arriving item's queue
    assign arr_head  = (i_direction == DIR_RL) ? r_rl_head : r_lr_head;
    assign arr_count = (i_direction == DIR_RL) ? r_rl_count : r_lr_count;
    assign tail_sum  = {1'b0, arr_head} + (IW + 1)'(arr_count);
    always_comb begin
        if (tail_sum >= DEPTH_X) begin
            tail_idx = IW'(tail_sum - DEPTH_X);
        end else begin
            tail_idx = tail_sum[IW-1:0];
        end
    end

    // Shared age compare on the selected queue's head
    assign sel_count  = (r_sel == DIR_RL) ? r_rl_count : r_lr_count;
    assign cand_tag   = (r_sel == DIR_RL) ? r_rl_rd_tag : r_lr_rd_tag;
    assign cand_stamp = (r_sel == DIR_RL) ? r_rl_rd_stamp : r_lr_rd_stamp;
    assign age        = r_time - cand_stamp;
    assign q_due      = (age >= {{(STAMP_W - DELAY_W){1'b0}}, r_delay});
    assign q_skip     = (sel_count == '0) || (r_k == CAP_C);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == MODE_TICK)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (q_skip) begin
                    n_state = (r_sel == DIR_LR) ? S_READ : S_FLUSH;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (q_due) begin
                    n_state = S_READ;
                end else begin
                    n_state = (r_sel == DIR_LR) ? S_READ : S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_time       = r_time;
        n_lr_head    = r_lr_head;
        n_rl_head    = r_rl_head;
        n_lr_count   = r_lr_count;
        n_rl_count   = r_rl_count;
        n_sel        = r_sel;
        n_k          = r_k;
        n_pend_valid = r_pend_valid;
        n_pend_tag   = r_pend_tag;
        n_pend_dir   = r_pend_dir;
        n_valid      = 1'b0;
        n_out_tag    = r_out_tag;
        n_out_dir    = r_out_dir;
        n_dropped    = r_dropped;
        n_last       = r_last;
        wr_lr        = 1'b0;
        wr_rl        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == MODE_ARRIVAL)) begin
                    if (r_delay == '0) begin
                        // bypass the queues
                        n_valid   = 1'b1;
                        n_out_tag = in_tag;
                        n_out_dir = i_direction;
                        n_dropped = 1'b0;
                        n_last    = 1'b1;
                    end else if (arr_count == DEPTH_C) begin
                        // drop and flag
                        n_valid   = 1'b1;
                        n_out_tag = in_tag;
                        n_out_dir = i_direction;
                        n_dropped = 1'b1;
                        n_last    = 1'b1;
                    end else if (i_direction == DIR_RL) begin
                        wr_rl      = 1'b1;
                        n_rl_count = r_rl_count + 1'b1;
                    end else begin
                        wr_lr      = 1'b1;
                        n_lr_count = r_lr_count + 1'b1;
                    end
                end else if (accept) begin
                    // advance time and start the walk at the left-to-right queue
                    n_time       = r_time + 1'b1;
                    n_sel        = DIR_LR;
                    n_k          = '0;
                    n_pend_valid = 1'b0;
                end
            end
            S_READ: begin
                if (q_skip && (r_sel == DIR_LR)) begin
                    n_sel = DIR_RL;
                end
            end
            S_CHECK: begin
                if (q_due) begin
                    // pop the head, send the held result, hold this one
                    if (r_sel == DIR_RL) begin
                        n_rl_head  = (r_rl_head == LAST_IDX) ? '0 : r_rl_head + 1'b1;
                        n_rl_count = r_rl_count - 1'b1;
                    end else begin
                        n_lr_head  = (r_lr_head == LAST_IDX) ? '0 : r_lr_head + 1'b1;
                        n_lr_count = r_lr_count - 1'b1;
                    end
                    if (r_pend_valid) begin
                        n_valid   = 1'b1;
                        n_out_tag = r_pend_tag;
                        n_out_dir = r_pend_dir;
                        n_dropped = 1'b0;
                        n_last    = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_tag   = cand_tag;
                    n_pend_dir   = r_sel;
                    n_k          = r_k + 1'b1;
                end else if (r_sel == DIR_LR) begin
                    n_sel = DIR_RL;
                end
            end
            S_FLUSH: begin
                // send the held result as the last one
                if (r_pend_valid) begin
                    n_valid   = 1'b1;
                    n_out_tag = r_pend_tag;
                    n_out_dir = r_pend_dir;
                    n_dropped = 1'b0;
                    n_last    = 1'b1;
                end
                n_pend_valid = 1'b0;
            end
            default: begin
                n_pend_valid = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_delay      <= '0;
            r_time       <= '0;
            r_lr_head    <= '0;
            r_rl_head    <= '0;
            r_lr_count   <= '0;
            r_rl_count   <= '0;
            r_sel        <= DIR_LR;
            r_k          <= '0;
            r_pend_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_lr_head    <= n_lr_head;
            r_rl_head    <= n_rl_head;
            r_lr_count   <= n_lr_count;
            r_rl_count   <= n_rl_count;
            r_sel        <= n_sel;
            r_k          <= n_k;
            r_pend_valid <= n_pend_valid;
            r_valid      <= n_valid;
            if (cfg_wr) begin
                r_delay <= pwdata[DELAY_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_tag <= n_pend_tag;
        r_pend_dir <= n_pend_dir;
        r_out_tag  <= n_out_tag;
        r_out_dir  <= n_out_dir;
        r_dropped  <= n_dropped;
        r_last     <= n_last;
    end

    // Queue memories: write at the tail, read the head every cycle
    always_ff @(posedge i_clk) begin
        if (wr_lr) begin
            lr_tag_mem[tail_idx]   <= in_tag;
            lr_stamp_mem[tail_idx] <= r_time;
        end
        r_lr_rd_tag   <= lr_tag_mem[r_lr_head];
        r_lr_rd_stamp <= lr_stamp_mem[r_lr_head];
    end

    always_ff @(posedge i_clk) begin
        if (wr_rl) begin
            rl_tag_mem[tail_idx]   <= in_tag;
            rl_stamp_mem[tail_idx] <= r_time;
        end
        r_rl_rd_tag   <= rl_tag_mem[r_rl_head];
        r_rl_rd_stamp <= rl_stamp_mem[r_rl_head];
    end

    assign o_valid         = r_valid;
    assign o_out_tag       = TAG_PORT_W'(r_out_tag);
    assign o_out_direction = r_out_dir;
    assign o_dropped       = r_dropped;
    assign o_last          = r_last;

endmodule

`default_nettype wire
